// File: hdl/hsh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256/224 hash unit package
// Shared types, initial values, round constants and the SHA-256 sigma helpers.
// ----------------------------------------------------------------------------
package hsh_pkg;

    typedef logic [31:0] word_t;

    // One queued message word after classification.
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  count;
        logic        last;
    } hsh_item_t;

    localparam logic MODE_SHA256 = 1'b0;
    localparam logic MODE_SHA224 = 1'b1;

    localparam logic [2:0] LAST_IDX_256 = 3'd7;
    localparam logic [2:0] LAST_IDX_224 = 3'd6;

    localparam logic [2:0] FULL_WORD_BYTES = 3'd4;
    localparam logic [7:0] PAD_MARK        = 8'h80;

    localparam word_t IV_256 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t IV_224 [8] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t sig0(input word_t x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(input word_t x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// File: hdl/sha256_sha224_hash_unit.sv
// ----------------------------------------------------------------------------
// SHA-256/224 hash unit
// Streams message words in and returns the final digest one word at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tdata carries a message word (first byte in bits 31:24) and
//   the count of valid leading bytes; tlast closes the message. Counts above
//   four are taken as four.
//   Config channel: one write sets the digest mode (0 SHA-256, 1 SHA-224),
//   reloads the initial values and drops any message in progress. Write only
//   while the unit is idle.
//   Master stream: eight digest words (seven for SHA-224), word 0 first, with
//   tlast on the final word.
// Flow: each word leaves the queue and is then packed one byte at a time;
//   every full 64-byte block is loaded, run through 64 rounds and added to
//   the chain. After tlast, padding and one or two final blocks come before
//   the first digest word; digest words then follow one per cycle while the
//   receiver keeps accepting them.
// A small input queue lets the sender run ahead while the core compresses.
// Reset clears the queue, selects SHA-256 and starts a fresh message. When
//   the receiver stalls, hold the current digest word; the core waits.
// ----------------------------------------------------------------------------
module sha256_sha224_hash_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [31:0] data_word, [34:32] bytes_valid
    input  logic        s_tlast,    // last_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [31:0] digest_word, [34:32] word_index
    output logic        m_tlast,    // digest_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data    // digest_mode
);

    hsh_pkg::hsh_item_t item;
    logic               item_valid;
    logic               item_pop;
    logic [31:0]        out_word;
    logic [2:0]         out_index;

    // the config channel is always open
    assign cfg_ready = 1'b1;

    hsh_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata[31:0]),
        .in_count  (s_tdata[34:32]),
        .in_last   (s_tlast),
        .item_valid(item_valid),
        .item_pop  (item_pop),
        .item      (item)
    );

    hsh_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_pop  (item_pop),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_word  (out_word),
        .out_index (out_index),
        .out_last  (m_tlast)
    );

    // pack the digest transaction, zero fill to whole bytes
    assign m_tdata = {5'b00000, out_index, out_word};

endmodule

// File: hdl/hsh_front.sv
// ----------------------------------------------------------------------------
// SHA-256/224 input front end
// Accepts message words, clamps the byte count and queues them for the core.
// ----------------------------------------------------------------------------
module hsh_front #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [31:0]       in_data,
    input  logic [2:0]        in_count,
    input  logic              in_last,
    output logic              item_valid,
    input  logic              item_pop,
    output hsh_pkg::hsh_item_t item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hsh_pkg::hsh_item_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push;
    hsh_pkg::hsh_item_t push_item;

    assign in_ready   = (count_reg != CW'(DEPTH));
    assign item_valid = (count_reg != '0);
    assign push       = in_valid && in_ready;
    assign item       = mem[rd_ptr_reg];

    always_comb
    begin
        push_item.data  = in_data;
        // clamp oversized byte counts to a full word
        push_item.count = (in_count > hsh_pkg::FULL_WORD_BYTES) ?
                          hsh_pkg::FULL_WORD_BYTES : in_count;
        push_item.last  = in_last;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (item_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !item_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && item_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> item_valid)
        else $error("pop from empty queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !item_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance");
    a_full_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue overfilled");
`endif

endmodule

// File: hdl/hsh_core.sv
// ----------------------------------------------------------------------------
// SHA-256/224 compression core
// Packs bytes, pads, runs one round per cycle and emits the digest words.
// ----------------------------------------------------------------------------
module hsh_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_pop,
    input  hsh_pkg::hsh_item_t item,
    input  logic               cfg_valid,
    input  logic               cfg_data,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [31:0]        out_word,
    output logic [2:0]         out_index,
    output logic               out_last
);

    typedef enum logic [2:0] {
        S_IDLE, S_BYTE, S_PAD, S_LEN, S_LOAD, S_COMP, S_ADD, S_OUT
    } state_t;

    state_t        state_reg, state_next;
    logic          mode_reg, mode_next;
    logic [31:0]   chain_reg [8];
    logic [31:0]   chain_next [8];
    logic [31:0]   vars_reg [8];
    logic [31:0]   vars_next [8];
    logic [31:0]   buf_reg [16];
    logic [31:0]   buf_next [16];
    logic [31:0]   acc_reg, acc_next;
    logic [31:0]   word_reg, word_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic          last_reg, last_next;
    logic          pad_first_reg, pad_first_next;
    logic          pad_more_reg, pad_more_next;
    logic          final_reg, final_next;
    logic          len_ph_reg, len_ph_next;
    logic [63:0]   bits_reg, bits_next;
    logic [5:0]    fill_reg, fill_next;
    logic [5:0]    rnd_reg, rnd_next;
    logic [2:0]    oidx_reg, oidx_next;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   out_word_reg, out_word_next;
    logic [2:0]    out_index_reg, out_index_next;
    logic          out_last_reg, out_last_next;

    logic [7:0]    byte_in;
    logic [31:0]   placed;
    logic          word_done;
    logic [31:0]   t1, t2, w_new;
    logic [2:0]    last_idx;
    logic          out_free;

    assign item_pop  = (state_reg == S_IDLE) && item_valid;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;
    assign last_idx  = (mode_reg == hsh_pkg::MODE_SHA224) ?
                       hsh_pkg::LAST_IDX_224 : hsh_pkg::LAST_IDX_256;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        // byte merge into the word accumulator at the current fill position
        byte_in   = (state_reg == S_BYTE) ? word_reg[31:24] :
                    (pad_first_reg ? hsh_pkg::PAD_MARK : 8'h00);
        placed    = ((fill_reg[1:0] == 2'd0) ? 32'h0 : acc_reg) |
                    ({byte_in, 24'h0} >> {fill_reg[1:0], 3'b000});
        word_done = (fill_reg[1:0] == 2'd3);

        t1 = vars_reg[7] + hsh_pkg::bsig1(vars_reg[4]) +
             ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6])) +
             hsh_pkg::ROUND_K[rnd_reg] + buf_reg[0];
        t2 = hsh_pkg::bsig0(vars_reg[0]) +
             ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2]) ^
              (vars_reg[1] & vars_reg[2]));
        w_new = buf_reg[0] + hsh_pkg::sig0(buf_reg[1]) + buf_reg[9] +
                hsh_pkg::sig1(buf_reg[14]);

        state_next     = state_reg;
        mode_next      = mode_reg;
        chain_next     = chain_reg;
        vars_next      = vars_reg;
        buf_next       = buf_reg;
        acc_next       = acc_reg;
        word_next      = word_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        pad_first_next = pad_first_reg;
        pad_more_next  = pad_more_reg;
        final_next     = final_reg;
        len_ph_next    = len_ph_reg;
        bits_next      = bits_reg;
        fill_next      = fill_reg;
        rnd_next       = rnd_reg;
        oidx_next      = oidx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    word_next = item.data;
                    cnt_next  = item.count;
                    last_next = item.last;
                    if (item.count != 3'd0)
                    begin
                        state_next = S_BYTE;
                    end
                    else if (item.last)
                    begin
                        pad_first_next = 1'b1;
                        last_next      = 1'b0;
                        state_next     = S_PAD;
                    end
                end
            end
            S_BYTE:
            begin
                acc_next  = placed;
                word_next = {word_reg[23:0], 8'h00};
                cnt_next  = cnt_reg - 1'b1;
                bits_next = bits_reg + 64'd8;
                fill_next = fill_reg + 1'b1;
                if (word_done)
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        buf_next[i] = buf_reg[i + 1];
                    end
                    buf_next[15] = placed;
                end
                if (fill_reg == 6'd63)
                begin
                    state_next = S_LOAD;
                end
                else if (cnt_reg == 3'd1)
                begin
                    if (last_reg)
                    begin
                        pad_first_next = 1'b1;
                        last_next      = 1'b0;
                        state_next     = S_PAD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_PAD:
            begin
                acc_next       = placed;
                pad_first_next = 1'b0;
                fill_next      = fill_reg + 1'b1;
                if (word_done)
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        buf_next[i] = buf_reg[i + 1];
                    end
                    buf_next[15] = placed;
                end
                if (fill_reg == 6'd63)
                begin
                    // marker landed at byte 56 or later: close an extra block first
                    pad_more_next = 1'b1;
                    state_next    = S_LOAD;
                end
                else if (fill_reg == 6'd55)
                begin
                    len_ph_next = 1'b0;
                    state_next  = S_LEN;
                end
            end
            S_LEN:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    buf_next[i] = buf_reg[i + 1];
                end
                buf_next[15] = len_ph_reg ? bits_reg[31:0] : bits_reg[63:32];
                fill_next    = fill_reg + 6'd4;
                len_ph_next  = 1'b1;
                if (len_ph_reg)
                begin
                    final_next = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                vars_next  = chain_reg;
                rnd_next   = '0;
                state_next = S_COMP;
            end
            S_COMP:
            begin
                vars_next[7] = vars_reg[6];
                vars_next[6] = vars_reg[5];
                vars_next[5] = vars_reg[4];
                vars_next[4] = vars_reg[3] + t1;
                vars_next[3] = vars_reg[2];
                vars_next[2] = vars_reg[1];
                vars_next[1] = vars_reg[0];
                vars_next[0] = t1 + t2;
                for (int i = 0; i < 15; i++)
                begin
                    buf_next[i] = buf_reg[i + 1];
                end
                buf_next[15] = w_new;
                rnd_next     = rnd_reg + 1'b1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + vars_reg[i];
                end
                if (final_reg)
                begin
                    final_next = 1'b0;
                    oidx_next  = '0;
                    state_next = S_OUT;
                end
                else if (pad_more_reg)
                begin
                    // extra block done: zero fill the next one up to the length
                    pad_more_next = 1'b0;
                    state_next    = S_PAD;
                end
                else if (cnt_reg != 3'd0)
                begin
                    state_next = S_BYTE;
                end
                else if (last_reg)
                begin
                    pad_first_next = 1'b1;
                    last_next      = 1'b0;
                    state_next     = S_PAD;
                end
                else if (pad_first_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = chain_reg[oidx_reg];
                    out_index_next = oidx_reg;
                    out_last_next  = (oidx_reg == last_idx);
                    oidx_next      = oidx_reg + 1'b1;
                    if (oidx_reg == last_idx)
                    begin
                        chain_next = (mode_reg == hsh_pkg::MODE_SHA224) ?
                                     hsh_pkg::IV_224 : hsh_pkg::IV_256;
                        bits_next  = '0;
                        fill_next  = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // mode write abandons the message in progress
        if (cfg_valid)
        begin
            mode_next  = cfg_data;
            chain_next = cfg_data ? hsh_pkg::IV_224 : hsh_pkg::IV_256;
            bits_next  = '0;
            fill_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        vars_reg      <= vars_next;
        buf_reg       <= buf_next;
        acc_reg       <= acc_next;
        word_reg      <= word_next;
        out_word_reg  <= out_word_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= hsh_pkg::MODE_SHA256;
            chain_reg     <= hsh_pkg::IV_256;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            pad_first_reg <= 1'b0;
            pad_more_reg  <= 1'b0;
            final_reg     <= 1'b0;
            len_ph_reg    <= 1'b0;
            bits_reg      <= '0;
            fill_reg      <= '0;
            rnd_reg       <= '0;
            oidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            chain_reg     <= chain_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            pad_first_reg <= pad_first_next;
            pad_more_reg  <= pad_more_next;
            final_reg     <= final_next;
            len_ph_reg    <= len_ph_next;
            bits_reg      <= bits_next;
            fill_reg      <= fill_next;
            rnd_reg       <= rnd_next;
            oidx_reg      <= oidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (fill_reg == 6'd0))
        else $error("compression started on a partial block");
    a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |=> (rnd_reg == 6'd0))
        else $error("round counter not cleared at block start");
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |->
        (out_index_reg == hsh_pkg::LAST_IDX_256 ||
         out_index_reg == hsh_pkg::LAST_IDX_224))
        else $error("last digest word at wrong index");
`endif

endmodule
